@@ hdl/oal_pkg.sv @@
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and constants for the ordered array list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  // fixed port widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned MPOS_W  = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_DELETE = 3'd2,
    FUNC_POP    = 3'd3,
    FUNC_REMOVE = 3'd4,
    FUNC_FIND   = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  // direction and handling of the entries read during a walk
  typedef enum logic [1:0] {
    WALK_UP      = 2'd0,
    WALK_DN      = 2'd1,
    WALK_COMPACT = 2'd2,
    WALK_SCAN    = 2'd3
  } walk_mode_e;

  typedef enum logic [1:0] {
    POS_KEEP   = 2'd0,
    POS_CNT    = 2'd1,
    POS_CNT_M1 = 2'd2
  } pos_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_WALK,
    S_DRAIN,
    S_PUT,
    S_FIN,
    S_DELIVER
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       set_status;
    status_e    status;
    pos_sel_e   pos_sel;
    logic       walk_init;
    walk_mode_e mode;
    logic       rd_en;
    logic       put;
    logic       fin;
    logic       load_out;
  } oal_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              cnt_zero;
    logic              pos_gt_cnt;
    logic              pos_lt_cnt;
    logic              walk_last;
  } oal_stat_t;

endpackage

@@ hdl/ordered_array_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top
// Ordered list of data words in a single-port-read memory with an entry count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries func_i, item_value_i and
//   position_i; each transaction returns exactly one response transaction on
//   out_valid_o/out_ready_i with status, entry total, removed word and match
//   information.
//   Insert, delete, pop, remove and find read the affected entries one per
//   cycle through the memory read port.
//   Requests are processed one at a time; a new request is taken as soon as
//   the previous result sits in the output register, even if the receiver
//   has not taken it yet. While the receiver stalls with a result pending,
//   the next result waits in the delivery step and no further request is
//   accepted.
//   Reset clears the entry count and the handshake state; the memory contents
//   are left as they are and no clearing pass is run.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_top import oal_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [VALUE_W-1:0] item_value_i,
  input  logic [POS_W-1:0]   position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [TOTAL_W-1:0] entry_total_o,
  output logic [VALUE_W-1:0] result_word_o,
  output logic [MPOS_W-1:0]  match_position_o,
  output logic [TOTAL_W-1:0] match_total_o
);

  oal_cmd_t  cmd;
  oal_stat_t stat;

  oal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  oal_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .func_i           (func_i),
    .item_value_i     (item_value_i),
    .position_i       (position_i),
    .status_o         (status_o),
    .entry_total_o    (entry_total_o),
    .result_word_o    (result_word_o),
    .match_position_o (match_position_o),
    .match_total_o    (match_total_o)
  );

`ifndef SYNTHESIS
  // one request in flight: acceptance drops ready on the next cycle
  a_single_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  // never overwrite a pending response
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("output register loaded while holding a pending response");

  // the walk stops reading after its last entry
  a_walk_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en && stat.walk_last |=> !cmd.rd_en)
    else $error("memory walk ran past its last entry");

  // a taken response with nothing new behind it clears valid
  a_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !cmd.load_out |=> !out_valid_o)
    else $error("response valid stuck after transaction");
`endif

endmodule

@@ hdl/oal_ctrl.sv @@
// ----------------------------------------------------------------------------
// oal_ctrl
// Sequencer: decodes a request, runs the memory walk and hands off results.
// ----------------------------------------------------------------------------
module oal_ctrl import oal_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  oal_stat_t stat_i,
  output oal_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   slot_free;

  function automatic walk_mode_e mode_of(logic [FUNC_W-1:0] f);
    walk_mode_e m;
    unique case (f)
      FUNC_INSERT:          m = WALK_UP;
      FUNC_DELETE, FUNC_POP: m = WALK_DN;
      FUNC_REMOVE:          m = WALK_COMPACT;
      default:              m = WALK_SCAN;
    endcase
    return m;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign slot_free   = !out_vld_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.func)
          FUNC_APPEND: state_d = stat_i.full ? S_DELIVER : S_PUT;
          FUNC_INSERT: begin
            if (stat_i.pos_gt_cnt || stat_i.full) state_d = S_DELIVER;
            else if (stat_i.pos_lt_cnt)          state_d = S_INIT;
            else                                 state_d = S_PUT;
          end
          FUNC_DELETE: state_d = stat_i.pos_lt_cnt ? S_INIT : S_DELIVER;
          FUNC_POP, FUNC_REMOVE, FUNC_FIND:
                       state_d = stat_i.cnt_zero ? S_DELIVER : S_INIT;
          default:     state_d = S_DELIVER;
        endcase
      end
      S_INIT:  state_d = S_WALK;
      S_WALK: begin
        if (stat_i.walk_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = (stat_i.func == FUNC_INSERT) ? S_PUT : S_FIN;
      S_PUT:   state_d = S_DELIVER;
      S_FIN:   state_d = S_DELIVER;
      S_DELIVER: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.status     = ST_OK;
    cmd_o.pos_sel    = POS_KEEP;
    cmd_o.mode       = mode_of(stat_i.func);
    unique case (state_q)
      S_IDLE: cmd_o.capture = in_valid_i;
      S_DECODE: begin
        unique case (stat_i.func)
          FUNC_APPEND: begin
            cmd_o.set_status = stat_i.full;
            cmd_o.status     = ST_FULL;
            cmd_o.pos_sel    = POS_CNT;
          end
          FUNC_INSERT: begin
            cmd_o.set_status = stat_i.pos_gt_cnt || stat_i.full;
            cmd_o.status     = stat_i.pos_gt_cnt ? ST_RANGE : ST_FULL;
          end
          FUNC_DELETE: begin
            cmd_o.set_status = !stat_i.pos_lt_cnt;
            cmd_o.status     = ST_RANGE;
          end
          FUNC_POP: begin
            cmd_o.set_status = stat_i.cnt_zero;
            cmd_o.status     = ST_NONE;
            cmd_o.pos_sel    = POS_CNT_M1;
          end
          FUNC_REMOVE, FUNC_FIND: begin
            cmd_o.set_status = stat_i.cnt_zero;
            cmd_o.status     = ST_NONE;
          end
          default: ;
        endcase
      end
      S_INIT:    cmd_o.walk_init = 1'b1;
      S_WALK:    cmd_o.rd_en     = 1'b1;
      S_DRAIN:   ;
      S_PUT:     cmd_o.put       = 1'b1;
      S_FIN:     cmd_o.fin       = 1'b1;
      S_DELIVER: cmd_o.load_out  = slot_free;
      default:   ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load_out)   out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

@@ hdl/oal_datapath.sv @@
// ----------------------------------------------------------------------------
// oal_datapath
// Entry memory, entry count, walk pointers, match logic and result registers.
// ----------------------------------------------------------------------------
module oal_datapath import oal_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oal_cmd_t            cmd_i,
  output oal_stat_t           stat_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [VALUE_W-1:0]  item_value_i,
  input  logic [POS_W-1:0]    position_i,
  output logic [STAT_W-1:0]   status_o,
  output logic [TOTAL_W-1:0]  entry_total_o,
  output logic [VALUE_W-1:0]  result_word_o,
  output logic [MPOS_W-1:0]   match_position_o,
  output logic [TOTAL_W-1:0]  match_total_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_BITS-1:0] entry_mem [CAPACITY];

  // request
  logic [FUNC_W-1:0]    func_q;
  logic [WORD_BITS-1:0] val_q;
  logic [PW-1:0]        pos_q;
  // walk
  logic [CW-1:0]        cnt_q;
  logic [AW-1:0]        ptr_q;
  logic [AW-1:0]        rd_addr_q;
  logic                 rd_vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  walk_mode_e           mode_q;
  logic [CW-1:0]        wp_q;
  // working results
  status_e              stat_q;
  logic [WORD_BITS-1:0] word_q;
  logic [AW-1:0]        mpos_q;
  logic [CW-1:0]        mtot_q;
  // output register
  status_e              out_stat_q;
  logic [CW-1:0]        out_cnt_q;
  logic [WORD_BITS-1:0] out_word_q;
  logic [AW-1:0]        out_mpos_q;
  logic [CW-1:0]        out_mtot_q;

  logic [CW-1:0]        cnt_m1;
  logic                 hit;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 take_word;

  assign cnt_m1 = cnt_q - CW'(1);
  assign hit    = rd_vld_q && (rdata_q == val_q);

  assign stat_o.func       = func_q;
  assign stat_o.full       = (cnt_q == CW'(CAPACITY));
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.pos_gt_cnt = (pos_q > PW'(cnt_q));
  assign stat_o.pos_lt_cnt = (pos_q < PW'(cnt_q));
  // insert walks down to the insert position, the others up to the last entry
  assign stat_o.walk_last  = (mode_q == WALK_UP) ? (CW'(ptr_q) == CW'(pos_q))
                                                 : (CW'(ptr_q) == cnt_m1);

  // write port: either the new word or the word read in the previous cycle
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rdata_q;
    take_word = 1'b0;
    if (cmd_i.put) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_q);
      wr_data = val_q;
    end else if (rd_vld_q) begin
      unique case (mode_q)
        WALK_UP: begin
          wr_en   = 1'b1;
          wr_addr = rd_addr_q + AW'(1);
        end
        WALK_DN: begin
          if (CW'(rd_addr_q) == CW'(pos_q)) begin
            take_word = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_q - AW'(1);
          end
        end
        WALK_COMPACT: begin
          wr_en   = !hit;
          wr_addr = AW'(wp_q);
        end
        WALK_SCAN: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) entry_mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rdata_q <= entry_mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.put) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.fin) begin
        unique case (mode_q)
          WALK_DN:      cnt_q <= cnt_m1;
          WALK_COMPACT: cnt_q <= wp_q;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      val_q  <= WORD_BITS'(item_value_i);
      pos_q  <= PW'(position_i);
      stat_q <= ST_OK;
      word_q <= '0;
      mpos_q <= '0;
      mtot_q <= '0;
    end else begin
      if (cmd_i.set_status) stat_q <= cmd_i.status;

      unique case (cmd_i.pos_sel)
        POS_CNT:    pos_q <= PW'(cnt_q);
        POS_CNT_M1: pos_q <= PW'(cnt_m1);
        default:    ;
      endcase

      if (cmd_i.walk_init) begin
        mode_q <= cmd_i.mode;
        wp_q   <= '0;
        unique case (cmd_i.mode)
          WALK_UP: ptr_q <= AW'(cnt_m1);
          WALK_DN: ptr_q <= AW'(pos_q);
          default: ptr_q <= '0;
        endcase
      end else if (cmd_i.rd_en) begin
        ptr_q <= (mode_q == WALK_UP) ? ptr_q - AW'(1) : ptr_q + AW'(1);
      end
      if (cmd_i.rd_en) rd_addr_q <= ptr_q;

      if (take_word) word_q <= rdata_q;

      if (rd_vld_q && mode_q == WALK_COMPACT) begin
        if (hit) mtot_q <= mtot_q + CW'(1);
        else     wp_q   <= wp_q + CW'(1);
      end
      if (hit && mode_q == WALK_SCAN) begin
        if (mtot_q == '0) mpos_q <= rd_addr_q;
        mtot_q <= mtot_q + CW'(1);
      end

      if (cmd_i.fin && (mode_q == WALK_COMPACT || mode_q == WALK_SCAN) &&
          mtot_q == '0) begin
        stat_q <= ST_NONE;
      end
    end

    if (cmd_i.load_out) begin
      out_stat_q <= stat_q;
      out_cnt_q  <= cnt_q;
      out_word_q <= word_q;
      out_mpos_q <= mpos_q;
      out_mtot_q <= mtot_q;
    end
  end

  assign status_o         = out_stat_q;
  assign entry_total_o    = TOTAL_W'(out_cnt_q);
  assign result_word_o    = VALUE_W'(out_word_q);
  assign match_position_o = MPOS_W'(out_mpos_q);
  assign match_total_o    = TOTAL_W'(out_mtot_q);

endmodule
